### src/kth_distinct_smallest_select_core_macros.svh
// Assertion macros for the verification checker of the selection core.
// Depends on nothing; each macro expects clk and rst_n in scope.
`ifndef KTH_DISTINCT_SMALLEST_SELECT_CORE_MACROS_SVH
`define KTH_DISTINCT_SMALLEST_SELECT_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KDSS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kdss same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define KDSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kdss next-cycle check failed");

`endif

### src/kdss_pkg.sv
// Shared types and constants of the k-th distinct smallest selection core.
// Depends on nothing; used by the controller and the top level.
package kdss_pkg;

    // Operation codes of an input transaction.
    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_QUERY  = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESULT
    } state_t;

    // Flipping the sign bit turns signed order into unsigned order.
    localparam logic [31:0] SIGN_FLIP = 32'h8000_0000;

    // Memory port controls from the controller.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctrl_t;

    // Finished query result handed to the output register.
    typedef struct packed {
        logic               valid;
        logic               empty;
        logic signed [31:0] selected;
    } res_t;

endpackage

### src/kdss_store.sv
// Value store: single-port-write, single-port-read synchronous memory.
// Read data is registered. Depends on kdss_pkg.
module kdss_store #(
    parameter int DEPTH = 256
) (
    input  logic                         clk,
    input  kdss_pkg::mem_ctrl_t          ctrl,
    input  logic [$clog2(DEPTH)-1:0]     waddr,
    input  logic [31:0]                  wdata,
    input  logic [$clog2(DEPTH)-1:0]     raddr,
    output logic [31:0]                  rdata
);

    logic [31:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### src/kdss_ctrl.sv
// Controller: entry count, operation decode and the rank search over the store.
// Drives kdss_store and returns results as kdss_pkg::res_t. Depends on kdss_pkg.
module kdss_ctrl #(
    parameter int CAPACITY = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      operation,
    input  logic signed [31:0]              value,
    input  logic [8:0]                      rank,
    input  logic                            slot_free,
    output kdss_pkg::mem_ctrl_t             mem_ctrl,
    output logic [$clog2(CAPACITY)-1:0]     waddr,
    output logic [31:0]                     wdata,
    output logic [$clog2(CAPACITY)-1:0]     raddr,
    input  logic [31:0]                     rdata,
    output kdss_pkg::res_t                  res
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    kdss_pkg::state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          issue_reg, issue_next;
    logic          rvalid_reg, rvalid_next;
    logic          rlast_reg, rlast_next;
    logic          have_reg, have_next;
    logic          min_pass_reg, min_pass_next;
    logic          empty_reg, empty_next;
    logic [8:0]    steps_reg, steps_next;
    logic [31:0]   best_reg, best_next;
    logic [31:0]   cur_reg, cur_next;

    logic [31:0]   key;
    logic          take;
    logic [31:0]   best_sel;
    logic          have_sel;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= kdss_pkg::ST_IDLE;
            count_reg  <= '0;
            issue_reg  <= 1'b0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            issue_reg  <= issue_next;
            rvalid_reg <= rvalid_next;
        end
    end

    // Search datapath registers.
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        rlast_reg    <= rlast_next;
        have_reg     <= have_next;
        min_pass_reg <= min_pass_next;
        empty_reg    <= empty_next;
        steps_reg    <= steps_next;
        best_reg     <= best_next;
        cur_reg      <= cur_next;
    end

    // Candidate test on the entry read back from the store. The minimum
    // pass takes any smaller key; later passes only keys above the current.
    assign key      = rdata ^ kdss_pkg::SIGN_FLIP;
    assign take     = rvalid_reg && (min_pass_reg || (key > cur_reg))
                      && (!have_reg || (key < best_reg));
    assign best_sel = take ? key : best_reg;
    assign have_sel = have_reg || take;

    assign waddr = count_reg[AW-1:0];
    assign wdata = value;
    assign raddr = idx_reg[AW-1:0];

    // Result transaction, offered while the output slot is free.
    assign res.valid    = (state_reg == kdss_pkg::ST_RESULT) && slot_free;
    assign res.empty    = empty_reg;
    assign res.selected = signed'(cur_reg ^ kdss_pkg::SIGN_FLIP);

    assign in_ready = (state_reg == kdss_pkg::ST_IDLE);

    // Next state and memory controls.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        issue_next     = issue_reg;
        rvalid_next    = 1'b0;
        rlast_next     = rlast_reg;
        have_next      = have_reg;
        min_pass_next  = min_pass_reg;
        empty_next     = empty_reg;
        steps_next     = steps_reg;
        best_next      = best_reg;
        cur_next       = cur_reg;
        mem_ctrl.wr_en = 1'b0;
        mem_ctrl.rd_en = 1'b0;

        unique case (state_reg)
            kdss_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (operation)
                        kdss_pkg::OP_APPEND:
                        begin
                            // Appends beyond capacity are dropped.
                            if (count_reg < CW'(CAPACITY))
                            begin
                                mem_ctrl.wr_en = 1'b1;
                                count_next     = count_reg + 1'b1;
                            end
                        end
                        kdss_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        kdss_pkg::OP_QUERY:
                        begin
                            if (count_reg == '0)
                            begin
                                // Empty set: selected reads as zero.
                                empty_next = 1'b1;
                                cur_next   = kdss_pkg::SIGN_FLIP;
                                state_next = kdss_pkg::ST_RESULT;
                            end
                            else
                            begin
                                empty_next    = 1'b0;
                                steps_next    = (rank > 9'd1) ? rank - 9'd1 : 9'd0;
                                min_pass_next = 1'b1;
                                have_next     = 1'b0;
                                idx_next      = '0;
                                issue_next    = 1'b1;
                                state_next    = kdss_pkg::ST_SCAN;
                            end
                        end
                        default:
                        begin
                            // Unused code: no effect.
                        end
                    endcase
                end
            end

            kdss_pkg::ST_SCAN:
            begin
                // Issue one read a cycle until the last stored entry.
                if (issue_reg)
                begin
                    mem_ctrl.rd_en = 1'b1;
                    idx_next       = idx_reg + 1'b1;
                    rlast_next     = (idx_reg == count_reg - 1'b1);
                    if (idx_reg == count_reg - 1'b1)
                    begin
                        issue_next = 1'b0;
                    end
                end
                rvalid_next = issue_reg;

                // Fold in returned data; decide at the end of each pass.
                if (rvalid_reg && rlast_reg)
                begin
                    have_next = 1'b0;
                    if (!have_sel)
                    begin
                        // Nothing above the current value: it is the maximum.
                        state_next = kdss_pkg::ST_RESULT;
                    end
                    else
                    begin
                        cur_next = best_sel;
                        if ((min_pass_reg && (steps_reg == 9'd0))
                            || (!min_pass_reg && (steps_reg == 9'd1)))
                        begin
                            state_next = kdss_pkg::ST_RESULT;
                        end
                        else
                        begin
                            if (!min_pass_reg)
                            begin
                                steps_next = steps_reg - 9'd1;
                            end
                            min_pass_next = 1'b0;
                            idx_next      = '0;
                            issue_next    = 1'b1;
                        end
                    end
                end
                else if (rvalid_reg)
                begin
                    best_next = best_sel;
                    have_next = have_sel;
                end
            end

            kdss_pkg::ST_RESULT:
            begin
                if (slot_free)
                begin
                    state_next = kdss_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = kdss_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### src/kth_distinct_smallest_select_core.sv
// Append and clear keep the core idle; the next item is accepted the cycle after.
// A query makes P passes over the N stored entries, with P = min(max(k, 1), distinct)
// plus one when k exceeds the distinct count (P = 0 when empty); the result enters
// the output register once that is free, and the next item is accepted from then on,
// so queries run one at a time.
// Reset clears the entry count and control state; the store needs no clearing.
module kth_distinct_smallest_select_core #(
    parameter int CAPACITY = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         operation,
    input  logic signed [31:0] value,
    input  logic [8:0]         rank,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] selected,
    output logic               empty_res
);

    localparam int AW = $clog2(CAPACITY);

    kdss_pkg::mem_ctrl_t mem_ctrl;
    kdss_pkg::res_t      res;
    logic [AW-1:0]       waddr;
    logic [AW-1:0]       raddr;
    logic [31:0]         wdata;
    logic [31:0]         rdata;
    logic                slot_free;

    logic                out_valid_reg;
    logic signed [31:0]  selected_reg;
    logic                empty_res_reg;

    kdss_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .value     (value),
        .rank      (rank),
        .slot_free (slot_free),
        .mem_ctrl  (mem_ctrl),
        .waddr     (waddr),
        .wdata     (wdata),
        .raddr     (raddr),
        .rdata     (rdata),
        .res       (res)
    );

    kdss_store #(
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .ctrl  (mem_ctrl),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Output register: the slot frees when it is empty or being taken.
    assign slot_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            selected_reg  <= res.selected;
            empty_res_reg <= res.empty;
        end
    end

    assign out_valid = out_valid_reg;
    assign selected  = selected_reg;
    assign empty_res = empty_res_reg;

endmodule

### src/kdss_checker.sv
// Port-level checks of the selection core, bound to its top level.
// Depends on kdss_pkg and kth_distinct_smallest_select_core_macros.svh.
`include "kth_distinct_smallest_select_core_macros.svh"

module kdss_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic [1:0]         operation,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] selected,
    input logic               empty_res
);

    logic in_fire;
    logic out_stall;
    logic write_fire;

    assign in_fire    = in_valid && in_ready;
    assign out_stall  = out_valid && !out_ready;
    assign write_fire = in_fire && ((operation == kdss_pkg::OP_APPEND)
                                    || (operation == kdss_pkg::OP_CLEAR));

    // A stalled result transaction holds its payload.
    `KDSS_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(selected) && $stable(empty_res))

    // An empty-set result always reports zero.
    `KDSS_ASSERT_NOW(a_empty_zero, out_valid && empty_res, selected == 32'sd0)

    // A query occupies the block for at least the following cycle.
    `KDSS_ASSERT_NEXT(a_query_busy, in_fire && (operation == kdss_pkg::OP_QUERY), !in_ready)

    // Append and clear leave the block ready again in the following cycle.
    `KDSS_ASSERT_NEXT(a_write_quick, write_fire, in_ready)

endmodule

bind kth_distinct_smallest_select_core kdss_checker u_kdss_checker (.*);

### dv/kth_distinct_smallest_select_core_test.sv
// Self-checking testbench for kth_distinct_smallest_select_core: directed and random
// append, query and clear transactions, checked against an in-bench model of the set.
// Depends on kdss_pkg and the core RTL; needs no files or arguments.
module kth_distinct_smallest_select_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH = 256;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [8:0] RANK_TOP = 9'd256;
    localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES = 20;
    localparam int RANDOM_ITEMS = 100;

    // One expected query answer.
    typedef struct packed {
        logic signed [31:0] selected;
        logic               empty;
    } answer_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         operation;
    logic signed [31:0] value;
    logic [8:0]         rank;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] selected;
    logic               empty_res;

    // Mirror of the stored set and the answers still owed by the core.
    logic signed [31:0] model_values[$];
    answer_t            expected_answers[$];
    int                 error_count = 0;
    int                 burst_left = 0;
    bit                 hold_off_req = 1'b0;

    kth_distinct_smallest_select_core #(
        .CAPACITY(STORE_DEPTH)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .operation(operation),
        .value(value),
        .rank(rank),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .selected(selected),
        .empty_res(empty_res)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Walk up from the minimum through distinct values, one step per rank.
    function automatic answer_t kth_distinct_value(input logic [8:0] rk);
        answer_t            ans;
        logic signed [31:0] cur;
        logic signed [31:0] best;
        bit                 have;
        int unsigned        step;
        ans.selected = '0;
        ans.empty = 1'b1;
        if (model_values.size() == 0)
            return ans;
        cur = model_values[0];
        foreach (model_values[i])
            if (model_values[i] < cur)
                cur = model_values[i];
        for (step = 1; step < rk; step++)
        begin
            have = 1'b0;
            best = cur;
            foreach (model_values[i])
                if (model_values[i] > cur && (!have || model_values[i] < best))
                begin
                    best = model_values[i];
                    have = 1'b1;
                end
            if (!have)
                break;
            cur = best;
        end
        ans.selected = cur;
        ans.empty = 1'b0;
        return ans;
    endfunction

    // Offer one transaction in bursts with random gaps, then update the model on acceptance.
    task automatic send_item(input logic [1:0] op, input logic signed [31:0] val,
                             input logic [8:0] rk);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        operation <= op;
        value <= val;
        rank <= rk;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        case (op)
            kdss_pkg::OP_APPEND:
            begin
                if (model_values.size() < STORE_DEPTH)
                    model_values.push_back(val);
            end
            kdss_pkg::OP_CLEAR:
                model_values.delete();
            kdss_pkg::OP_QUERY:
                expected_answers.push_back(kth_distinct_value(rk));
            default:
                ;
        endcase
    endtask

    // Unused fields carry random content.
    task automatic append_value(input logic signed [31:0] val);
        send_item(kdss_pkg::OP_APPEND, val, 9'($urandom_range(0, 256)));
    endtask

    task automatic query_rank(input logic [8:0] rk);
        send_item(kdss_pkg::OP_QUERY, $urandom, rk);
    endtask

    task automatic clear_set();
        send_item(kdss_pkg::OP_CLEAR, $urandom, 9'($urandom_range(0, 256)));
    endtask

    task automatic unused_op();
        send_item(OP_UNUSED, $urandom, 9'($urandom_range(0, 256)));
    endtask

    // Stop offering and wait until every owed answer has come back.
    task automatic wait_for_answers();
        in_valid <= 1'b0;
        while (expected_answers.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        burst_left = 0;
    endtask

    // Mix of duplicates, extremes and full-range values.
    function automatic logic signed [31:0] random_value();
        case ($urandom_range(0, 5))
            0, 1:    return 32'($signed($urandom_range(0, 6)) - 3);
            2:       return ($urandom_range(0, 1) != 0) ? INT_MAX : INT_MIN;
            3:       return INT_MIN + 32'($urandom_range(0, 3));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [8:0] random_rank();
        case ($urandom_range(0, 5))
            0:       return 9'd0;
            1:       return 9'd1;
            2:       return RANK_TOP;
            3:       return 9'($urandom_range(0, 256));
            default: return 9'($urandom_range(0, model_values.size() + 2));
        endcase
    endfunction

    // Queries on an empty set, an ignored operation code and a clear with nothing stored.
    task automatic test_empty_set();
        query_rank(9'd0);
        unused_op();
        clear_set();
        query_rank(RANK_TOP);
        wait_for_answers();
    endtask

    // Extremes with duplicates: ranks zero, one, within range and beyond the distinct count.
    task automatic test_value_extremes();
        append_value(INT_MAX);
        append_value(INT_MIN);
        append_value(32'sd0);
        append_value(-32'sd1);
        append_value(INT_MAX);
        append_value(32'sd1);
        query_rank(9'd0);
        query_rank(9'd1);
        query_rank(9'd2);
        query_rank(9'd5);
        query_rank(9'd6);
        query_rank(RANK_TOP);
        unused_op();
        query_rank(9'd3);
        clear_set();
        query_rank(9'd1);
        append_value(-32'sd7);
        query_rank(RANK_TOP);
        wait_for_answers();
    endtask

    // Fill the store with distinct values, check that extra appends are dropped,
    // then clear and make sure stale entries stay invisible.
    task automatic test_full_store();
        logic [31:0] offset;
        int          i;
        offset = $urandom;
        clear_set();
        for (i = 0; i < STORE_DEPTH; i++)
            append_value($signed(32'(i) * 32'h9E37_79B9 + offset));
        append_value(INT_MIN);
        append_value(INT_MAX);
        append_value(random_value());
        query_rank(9'd1);
        query_rank(9'd2);
        query_rank(RANK_TOP);
        clear_set();
        append_value(random_value());
        append_value(random_value());
        query_rank(RANK_TOP);
        query_rank(9'd0);
        wait_for_answers();
    endtask

    // Receiver holds off for a long stretch while queries keep coming.
    task automatic test_backpressure();
        int i;
        clear_set();
        repeat (4) append_value(random_value());
        hold_off_req = 1'b1;
        for (i = 0; i < 10; i++)
        begin
            query_rank(random_rank());
            if (i % 4 == 3)
                append_value(random_value());
        end
        wait_for_answers();
    endtask

    // Random transaction sequences on small sets, with a little noise.
    task automatic test_random_traffic();
        int items;
        int count;
        int pick;
        items = 0;
        while (items < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0 || model_values.size() > 32)
            begin
                clear_set();
                items++;
            end
            else if (pick <= 4)
            begin
                count = $urandom_range(1, 8);
                repeat (count) append_value(random_value());
                items += count;
            end
            else if (pick <= 8)
            begin
                query_rank(random_rank());
                items++;
            end
            else
                unused_op();
        end
    endtask

    // Stimulus and final verdict.
    initial
    begin : stimulus
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        operation <= kdss_pkg::OP_APPEND;
        value <= '0;
        rank <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_set();
        test_value_extremes();
        test_full_store();
        test_backpressure();
        test_random_traffic();
        wait_for_answers();
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Result side: a changing stall pattern, plus a long hold-off on request.
    initial
    begin : result_receiver
        int stretch;
        int mode;
        int held;
        out_ready <= 1'b0;
        forever
        begin
            stretch = $urandom_range(4, 40);
            mode = $urandom_range(0, 3);
            repeat (stretch)
            begin
                @(posedge clk);
                if (hold_off_req)
                begin
                    hold_off_req = 1'b0;
                    out_ready <= 1'b0;
                    for (held = 0; held < HOLD_OFF_CYCLES; held++)
                        @(posedge clk);
                end
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    2:       out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Compare each accepted result transaction with the oldest owed answer.
    initial
    begin : result_checker
        answer_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (expected_answers.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual selected=%0d empty=%0b",
                             $realtime, selected, empty_res);
                    error_count++;
                end
                else
                begin
                    want = expected_answers.pop_front();
                    if (selected !== want.selected)
                    begin
                        $display("%0t: selected mismatch, expected %0d, actual %0d",
                                 $realtime, want.selected, selected);
                        error_count++;
                    end
                    if (empty_res !== want.empty)
                    begin
                        $display("%0t: empty_res mismatch, expected %0b, actual %0b",
                                 $realtime, want.empty, empty_res);
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog far beyond the slowest legal run.
    initial
    begin : watchdog
        #40_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
